### hdl/psf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psf_pkg
// Shared constants, codes and types of the scanline polygon span fill.
// ----------------------------------------------------------------------------
package psf_pkg;

    localparam int PSF_MAX_VERTICES = 64;
    localparam int PSF_COORD_BITS   = 16;
    localparam int MAX_SPANS        = 32;
    localparam int MIN_POLY         = 3;

    // request kinds
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_FILL   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_LD0,
        ST_RDN,
        ST_EDGE,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_RND,
        ST_INS,
        ST_INS_CMP,
        ST_NEXT,
        ST_E_RD0,
        ST_E_RD1,
        ST_E_CHK,
        ST_E_PUT
    } psf_state_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

### hdl/psf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psf_if
// Request and span channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface psf_item_if import psf_pkg::*; #(parameter int COORD_BITS = PSF_COORD_BITS);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] scan_y;

    modport source (output valid, kind, vertex_x, vertex_y, scan_y, input ready);
    modport sink   (input valid, kind, vertex_x, vertex_y, scan_y, output ready);
endinterface

interface psf_span_if import psf_pkg::*; #(parameter int COORD_BITS = PSF_COORD_BITS);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] span_y;
    logic signed [COORD_BITS-1:0] span_start_x;
    logic signed [COORD_BITS-1:0] span_end_x;
    logic                         last_span;

    modport source (output valid, span_y, span_start_x, span_end_x, last_span, input ready);
    modport sink   (input valid, span_y, span_start_x, span_end_x, last_span, output ready);
endinterface
`default_nettype wire

### hdl/psf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psf_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module psf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hdl/psf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psf_div import psf_pkg::*; #(
    parameter int NW = 32,
    parameter int DW = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output div_stat_t          stat,
    output logic      [NW-1:0] quot,
    output logic      [DW-1:0] rem
);
    localparam int CNTW = $clog2(NW + 1);

    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [NW-1:0]   num_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   den_reg;
    logic [DW:0]     trial;
    logic            qbit;
    logic [DW:0]     diff;

    // one shift-subtract step
    always_comb
    begin
        trial = {rem_reg, num_reg[NW-1]};
        diff  = trial - {1'b0, den_reg};
        qbit  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], qbit};
            rem_reg <= qbit ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = num_reg;
    assign rem       = rem_reg;
endmodule
`default_nettype wire

### hdl/scanline_polygon_span_fill.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scanline_polygon_span_fill
// Holds a polygon and its x extent; emits the clamped filled spans of a row.
// ----------------------------------------------------------------------------
// channel  dir  modport  payload
// item     in   sink     kind, vertex_x, vertex_y, scan_y
// span     out  source   span_y, span_start_x, span_end_x, last_span
//
// Clear and append are taken while idle. A fill fetches vertex zero, then tests
// each edge against the row; a crossing edge is multiplied, divided in the
// serial divider and rounded, then inserted, shifting larger crossings up.
// Emission reads each crossing pair, emits it or drops it when empty, and finishes.
// Reset clears the vertex count and control; RAM contents stay undefined.
// A stalled span output holds the sequencer; no request is taken meanwhile.
// ----------------------------------------------------------------------------
module scanline_polygon_span_fill import psf_pkg::*; #(
    parameter int MAX_VERTICES = PSF_MAX_VERTICES,
    parameter int COORD_BITS   = PSF_COORD_BITS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    psf_item_if.sink   item,
    psf_span_if.source span
);
    localparam int C  = COORD_BITS;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int SW = $clog2(MAX_SPANS + 1);

    psf_state_t state_reg, state_next;

    // polygon state
    logic [CW-1:0]       vcount_reg;
    logic signed [C-1:0] box_min_x_reg, box_max_x_reg;

    // fill walk
    logic signed [C-1:0] y_reg;
    logic signed [C-1:0] v0_x_reg, v0_y_reg, prev_x_reg, prev_y_reg;
    logic                use_v0_reg;
    logic [CW-1:0]       i_reg, nc_reg, j_reg, idx_reg;
    logic signed [C-1:0] xa_reg;
    logic [C-1:0]        d_reg, t_reg, adx_reg;
    logic                neg_reg;
    logic [2*C-1:0]      prod_reg;
    logic [C-1:0]        q_reg, r_reg;
    logic signed [C-1:0] v_reg;

    // emission
    logic signed [C-1:0] a_reg, cs_reg, ce_reg, ps_reg, pe_reg;
    logic                pend_reg;
    logic [SW-1:0]       cnt_reg;

    // output register
    logic                out_valid_reg, out_last_reg;
    logic signed [C-1:0] out_y_reg, out_s_reg, out_e_reg;

    // memories
    logic                vr_we;
    logic [AW-1:0]       vr_waddr, vr_raddr;
    logic [2*C-1:0]      vr_rdata;
    logic                cr_we;
    logic [AW-1:0]       cr_waddr, cr_raddr;
    logic [C-1:0]        cr_wdata, cr_rdata;

    logic                div_start;
    div_stat_t           div_stat;
    logic [2*C-1:0]      div_quot;
    logic [C-1:0]        div_rem;

    logic                out_free;
    logic                accept;
    logic                can_append;

    psf_ram #(.WIDTH(2 * C), .DEPTH(MAX_VERTICES)) u_vram (
        .clk   (clk),
        .we    (vr_we),
        .waddr (vr_waddr),
        .wdata ({item.vertex_x, item.vertex_y}),
        .raddr (vr_raddr),
        .rdata (vr_rdata)
    );

    psf_ram #(.WIDTH(C), .DEPTH(MAX_VERTICES)) u_cram (
        .clk   (clk),
        .we    (cr_we),
        .waddr (cr_waddr),
        .wdata (cr_wdata),
        .raddr (cr_raddr),
        .rdata (cr_rdata)
    );

    psf_div #(.NW(2 * C), .DW(C)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (d_reg),
        .stat  (div_stat),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    assign out_free   = !out_valid_reg || span.ready;
    assign accept     = item.valid && (state_reg == ST_IDLE);
    assign can_append = (vcount_reg < CW'(MAX_VERTICES));

    // next vertex of the current edge, closing edge wraps to vertex zero
    logic signed [C-1:0] nx, ny;
    logic                edge_up, edge_hit;
    always_comb
    begin
        nx       = use_v0_reg ? v0_x_reg : vr_rdata[2*C-1:C];
        ny       = use_v0_reg ? v0_y_reg : vr_rdata[C-1:0];
        edge_up  = prev_y_reg < ny;
        if (prev_y_reg == ny)
            edge_hit = 1'b0;
        else if (edge_up)
            edge_hit = (y_reg >= prev_y_reg) && (y_reg < ny);
        else
            edge_hit = (y_reg >= ny) && (y_reg < prev_y_reg);
    end

    // rounding of the exact quotient, ties away from zero
    logic signed [C+1:0] fl;
    logic [C-1:0]        f;
    logic                rnd_up;
    always_comb
    begin
        if (!neg_reg)
        begin
            fl = (C+2)'(xa_reg) + $signed({2'b00, q_reg});
            f  = r_reg;
        end
        else
        begin
            fl = (C+2)'(xa_reg) - $signed({2'b00, q_reg})
               - $signed({{(C+1){1'b0}}, (r_reg != '0)});
            f  = (r_reg != '0) ? d_reg - r_reg : '0;
        end
        rnd_up = ({f, 1'b0} > {1'b0, d_reg})
              || (({f, 1'b0} == {1'b0, d_reg}) && !fl[C+1]);
    end

    // span clamp of the captured pair
    logic signed [C-1:0] cl_s, cl_e, b_val;
    always_comb
    begin
        b_val = cr_rdata;
        cl_s  = (a_reg < box_min_x_reg) ? box_min_x_reg : a_reg;
        cl_e  = (b_val > box_max_x_reg) ? box_max_x_reg : b_val;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && item.kind == KIND_FILL && vcount_reg >= CW'(MIN_POLY))
                    state_next = ST_RD0;
            ST_RD0:     state_next = ST_LD0;
            ST_LD0:     state_next = ST_RDN;
            ST_RDN:     state_next = ST_EDGE;
            ST_EDGE:    state_next = edge_hit ? ST_MUL : ST_NEXT;
            ST_MUL:     state_next = ST_DSTART;
            ST_DSTART:  state_next = ST_DIV;
            ST_DIV:     if (div_stat.done) state_next = ST_RND;
            ST_RND:     state_next = ST_INS;
            ST_INS:     state_next = (j_reg == '0) ? ST_NEXT : ST_INS_CMP;
            ST_INS_CMP: state_next = ($signed(cr_rdata) > v_reg) ? ST_INS : ST_NEXT;
            ST_NEXT:
                state_next = (i_reg + 1'b1 == vcount_reg) ? ST_E_RD0 : ST_RDN;
            ST_E_RD0:
                if ({1'b0, idx_reg} + 1'b1 >= {1'b0, nc_reg})
                begin
                    if (!pend_reg)
                        state_next = ST_IDLE;
                    else if (out_free)
                        state_next = ST_IDLE;
                end
                else
                    state_next = ST_E_RD1;
            ST_E_RD1:   state_next = ST_E_CHK;
            ST_E_CHK:   state_next = (cl_s <= cl_e) ? ST_E_PUT : ST_E_RD0;
            ST_E_PUT:
                if (!pend_reg || out_free)
                begin
                    if (cnt_reg + 1'b1 == SW'(MAX_SPANS))
                        state_next = ST_E_RD0;
                    else
                        state_next = ST_E_RD0;
                end
            default:    state_next = ST_IDLE;
        endcase
    end

    // memory and unit controls
    always_comb
    begin
        item.ready = (state_reg == ST_IDLE);
        vr_we      = accept && item.kind == KIND_APPEND && can_append;
        vr_waddr   = vcount_reg[AW-1:0];
        vr_raddr   = (state_reg == ST_RDN) ? AW'(i_reg + 1'b1) : '0;
        cr_we      = 1'b0;
        cr_waddr   = j_reg[AW-1:0];
        cr_wdata   = v_reg;
        cr_raddr   = '0;
        div_start  = (state_reg == ST_DSTART);
        case (state_reg)
            ST_INS:
            begin
                cr_raddr = AW'(j_reg - 1'b1);
                cr_we    = (j_reg == '0);
            end
            ST_INS_CMP:
            begin
                cr_we    = 1'b1;
                cr_wdata = ($signed(cr_rdata) > v_reg) ? cr_rdata : v_reg;
            end
            ST_E_RD0:   cr_raddr = idx_reg[AW-1:0];
            ST_E_RD1:   cr_raddr = AW'(idx_reg + 1'b1);
            default:    cr_raddr = '0;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vcount_reg    <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
            nc_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (span.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (accept && item.kind == KIND_CLEAR)
                        vcount_reg <= '0;
                    else if (vr_we)
                        vcount_reg <= vcount_reg + 1'b1;
                ST_RD0:
                begin
                    nc_reg   <= '0;
                    pend_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                ST_INS:
                    if (j_reg == '0)
                        nc_reg <= nc_reg + 1'b1;
                ST_INS_CMP:
                    if (!($signed(cr_rdata) > v_reg))
                        nc_reg <= nc_reg + 1'b1;
                ST_E_RD0:
                    if (({1'b0, idx_reg} + 1'b1 >= {1'b0, nc_reg}) && pend_reg && out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        pend_reg      <= 1'b0;
                    end
                ST_E_PUT:
                    if (!pend_reg || out_free)
                    begin
                        if (pend_reg)
                            out_valid_reg <= 1'b1;
                        pend_reg <= 1'b1;
                        cnt_reg  <= cnt_reg + 1'b1;
                        // span limit reached: no further pair is read
                        if (cnt_reg + 1'b1 == SW'(MAX_SPANS))
                            nc_reg <= '0;
                    end
                default:
                    nc_reg <= nc_reg;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    y_reg <= item.scan_y;
                    if (vr_we)
                    begin
                        if (vcount_reg == '0 || item.vertex_x < box_min_x_reg)
                            box_min_x_reg <= item.vertex_x;
                        if (vcount_reg == '0 || item.vertex_x > box_max_x_reg)
                            box_max_x_reg <= item.vertex_x;
                    end
                end
            ST_LD0:
            begin
                v0_x_reg   <= vr_rdata[2*C-1:C];
                v0_y_reg   <= vr_rdata[C-1:0];
                prev_x_reg <= vr_rdata[2*C-1:C];
                prev_y_reg <= vr_rdata[C-1:0];
                i_reg      <= '0;
            end
            ST_RDN:
                use_v0_reg <= (i_reg + 1'b1 == vcount_reg);
            ST_EDGE:
            begin
                prev_x_reg <= nx;
                prev_y_reg <= ny;
                if (edge_up)
                begin
                    xa_reg  <= prev_x_reg;
                    d_reg   <= C'(ny - prev_y_reg);
                    t_reg   <= C'(y_reg - prev_y_reg);
                    neg_reg <= nx < prev_x_reg;
                    adx_reg <= (nx < prev_x_reg) ? C'(prev_x_reg - nx) : C'(nx - prev_x_reg);
                end
                else
                begin
                    xa_reg  <= nx;
                    d_reg   <= C'(prev_y_reg - ny);
                    t_reg   <= C'(y_reg - ny);
                    neg_reg <= prev_x_reg < nx;
                    adx_reg <= (prev_x_reg < nx) ? C'(nx - prev_x_reg) : C'(prev_x_reg - nx);
                end
            end
            ST_MUL:
                prod_reg <= adx_reg * t_reg;
            ST_DIV:
            begin
                q_reg <= div_quot[C-1:0];
                r_reg <= div_rem;
            end
            ST_RND:
            begin
                v_reg <= C'(fl + (rnd_up ? 1 : 0));
                j_reg <= nc_reg;
            end
            ST_INS_CMP:
                if ($signed(cr_rdata) > v_reg)
                    j_reg <= j_reg - 1'b1;
            ST_NEXT:
            begin
                i_reg   <= i_reg + 1'b1;
                idx_reg <= '0;
            end
            ST_E_RD0:
                if (({1'b0, idx_reg} + 1'b1 >= {1'b0, nc_reg}) && pend_reg && out_free)
                begin
                    out_y_reg    <= y_reg;
                    out_s_reg    <= ps_reg;
                    out_e_reg    <= pe_reg;
                    out_last_reg <= 1'b1;
                end
            ST_E_RD1:
                a_reg <= cr_rdata;
            ST_E_CHK:
            begin
                cs_reg  <= cl_s;
                ce_reg  <= cl_e;
                idx_reg <= idx_reg + CW'(2);
            end
            ST_E_PUT:
                if (!pend_reg || out_free)
                begin
                    // the output register is loaded only with a pending span
                    if (pend_reg)
                    begin
                        out_y_reg    <= y_reg;
                        out_s_reg    <= ps_reg;
                        out_e_reg    <= pe_reg;
                        out_last_reg <= 1'b0;
                    end
                    ps_reg       <= cs_reg;
                    pe_reg       <= ce_reg;
                end
            default:
                a_reg <= a_reg;
        endcase
    end

    assign span.valid        = out_valid_reg;
    assign span.span_y       = out_y_reg;
    assign span.span_start_x = out_s_reg;
    assign span.span_end_x   = out_e_reg;
    assign span.last_span    = out_last_reg;

`ifndef SYNTHESIS
    // span count stays within the limit
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= SW'(MAX_SPANS))
        else $error("span count above limit");

    // crossings never outnumber vertices while a fill runs
    a_nc_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_reg != ST_RD0) |-> (nc_reg <= vcount_reg))
        else $error("crossing count above vertex count");

    // every emitted span is non-empty
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_s_reg <= out_e_reg))
        else $error("span start beyond end");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider result without waiting sequencer");
`endif
endmodule
`default_nettype wire
